>>> rtl/core/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

   // Field widths of the channels.
   localparam int HUE_W = 9;
   localparam int PCT_W = 7;
   localparam int CHAN_W = 8;

   // Hue wraps at a full turn; percentages saturate at one hundred.
   localparam int HUE_FULL = 360;
   localparam int PCT_MAX = 100;
   localparam int PCT_HALF = 50;

   // Per-channel hue offsets in degrees (red, green, blue).
   localparam logic [8:0] RED_OFFSET = 9'd0;
   localparam logic [8:0] GREEN_OFFSET = 9'd240;
   localparam logic [8:0] BLUE_OFFSET = 9'd120;

   // Corner points of the channel ramp and its clamp level.
   localparam int K_RISE = 90;
   localparam int K_FALL = 270;
   localparam int C_LIMIT = 30;

   // Lightness weight in the numerator.
   localparam int L_SCALE = 3000;

   // Internal widths.
   localparam int MIN_W = 6;    // min(l, 100 - l) is at most 50
   localparam int SM_W = 13;    // s * m is at most 5000
   localparam int NUM_W = 19;   // numerator is at most 300000
   localparam int C_W = 7;      // clamp value in -30..30

   // floor(255 * num / 300000) = floor(17 * num / 20000), done as a multiply by
   // 17 * ceil(2^38 / 20000) followed by a right shift of 38.
   localparam logic [27:0] RECIP_MULT = 28'd233646232;
   localparam int RECIP_SHIFT = 38;
   localparam int PROD_W = 47;

   // Per-stage load enables of the pipeline.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } hsl2rgb_stage_en_type;

endpackage

>>> rtl/core/hsl2rgb_ifs.sv
// Input channel: one HSL color per item.
interface hsl2rgb_req_if;
   logic                            valid;
   logic                            ready;
   logic [hsl2rgb_pkg::HUE_W-1:0]   hue;
   logic [hsl2rgb_pkg::PCT_W-1:0]   saturation;
   logic [hsl2rgb_pkg::PCT_W-1:0]   lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input lightness,
                 output ready);
endinterface

// Result channel: one RGB color per item.
interface hsl2rgb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hsl2rgb_pkg::CHAN_W-1:0]   red;
   logic [hsl2rgb_pkg::CHAN_W-1:0]   green;
   logic [hsl2rgb_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/hsl2rgb_front.sv
module hsl2rgb_front (
   input  logic                                clock,
   input  hsl2rgb_pkg::hsl2rgb_stage_en_type   stage_en,
   input  logic [hsl2rgb_pkg::HUE_W-1:0]       hue,
   input  logic [hsl2rgb_pkg::PCT_W-1:0]       saturation,
   input  logic [hsl2rgb_pkg::PCT_W-1:0]       lightness,
   output logic [hsl2rgb_pkg::HUE_W-1:0]       hue_s1,
   output logic [hsl2rgb_pkg::SM_W-1:0]        sm_s2,
   output logic [hsl2rgb_pkg::NUM_W-1:0]       lscaled_s2
);

   logic [hsl2rgb_pkg::HUE_W-1:0] hue_in, hue_ff;
   logic [hsl2rgb_pkg::PCT_W-1:0] sat_in, sat_ff;
   logic [hsl2rgb_pkg::PCT_W-1:0] light_in, light_ff;
   logic [hsl2rgb_pkg::MIN_W-1:0] min_in, min_ff;
   logic [hsl2rgb_pkg::PCT_W-1:0] light_rest;
   logic [hsl2rgb_pkg::SM_W-1:0]  sm_in, sm_ff;
   logic [hsl2rgb_pkg::NUM_W-1:0] lscaled_in, lscaled_ff;

   // Stage 1: wrap the hue into 0..359 and saturate the percentages.
   always_comb begin
      if (hue >= hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_FULL)) begin
         hue_in = hue - hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_FULL);
      end else begin
         hue_in = hue;
      end
      if (saturation > hsl2rgb_pkg::PCT_W'(hsl2rgb_pkg::PCT_MAX)) begin
         sat_in = hsl2rgb_pkg::PCT_W'(hsl2rgb_pkg::PCT_MAX);
      end else begin
         sat_in = saturation;
      end
      if (lightness > hsl2rgb_pkg::PCT_W'(hsl2rgb_pkg::PCT_MAX)) begin
         light_in = hsl2rgb_pkg::PCT_W'(hsl2rgb_pkg::PCT_MAX);
      end else begin
         light_in = lightness;
      end
   end

   // The smaller of l and 100 - l, taken from the saturated lightness.
   assign light_rest = hsl2rgb_pkg::PCT_W'(hsl2rgb_pkg::PCT_MAX) - light_in;
   assign min_in = (light_in < light_rest) ? light_in[hsl2rgb_pkg::MIN_W-1:0]
                                           : light_rest[hsl2rgb_pkg::MIN_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
         min_ff   <= min_in;
      end
   end

   // Stage 2: the two products shared by all three channels.
   assign sm_in = hsl2rgb_pkg::SM_W'(sat_ff) * hsl2rgb_pkg::SM_W'(min_ff);
   assign lscaled_in = hsl2rgb_pkg::NUM_W'(light_ff)
                       * hsl2rgb_pkg::NUM_W'(hsl2rgb_pkg::L_SCALE);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         sm_ff      <= sm_in;
         lscaled_ff <= lscaled_in;
      end
   end

   assign hue_s1     = hue_ff;
   assign sm_s2      = sm_ff;
   assign lscaled_s2 = lscaled_ff;

endmodule

>>> rtl/core/hsl2rgb_chan.sv
module hsl2rgb_chan (
   input  logic                                clock,
   input  hsl2rgb_pkg::hsl2rgb_stage_en_type   stage_en,
   input  logic [8:0]                          offset,
   input  logic [hsl2rgb_pkg::HUE_W-1:0]       hue_s1,
   input  logic [hsl2rgb_pkg::SM_W-1:0]        sm_s2,
   input  logic [hsl2rgb_pkg::NUM_W-1:0]       lscaled_s2,
   output logic [hsl2rgb_pkg::CHAN_W-1:0]      level
);

   logic [9:0]                            k_sum;
   logic [8:0]                            k_pos;
   logic signed [9:0]                     rise, fall, c_min;
   logic signed [hsl2rgb_pkg::C_W-1:0]    c_in, c_ff;
   logic signed [20:0]                    term, num_full;
   logic [hsl2rgb_pkg::NUM_W-1:0]         num_in, num_ff;
   logic [hsl2rgb_pkg::PROD_W-1:0]        scaled;
   logic [hsl2rgb_pkg::CHAN_W-1:0]        level_in, level_ff;

   // Stage 2: shifted hue and the clamped ramp value C.
   always_comb begin
      k_sum = {1'b0, hue_s1} + {1'b0, offset};
      if (k_sum >= 10'(hsl2rgb_pkg::HUE_FULL)) begin
         k_pos = 9'(k_sum - 10'(hsl2rgb_pkg::HUE_FULL));
      end else begin
         k_pos = k_sum[8:0];
      end
      rise  = $signed({1'b0, k_pos}) - $signed(10'(hsl2rgb_pkg::K_RISE));
      fall  = $signed(10'(hsl2rgb_pkg::K_FALL)) - $signed({1'b0, k_pos});
      c_min = (fall < rise) ? fall : rise;
      if (c_min > $signed(10'(hsl2rgb_pkg::C_LIMIT))) begin
         c_in = $signed(hsl2rgb_pkg::C_W'(hsl2rgb_pkg::C_LIMIT));
      end else if (c_min < -$signed(10'(hsl2rgb_pkg::C_LIMIT))) begin
         c_in = -$signed(hsl2rgb_pkg::C_W'(hsl2rgb_pkg::C_LIMIT));
      end else begin
         c_in = c_min[hsl2rgb_pkg::C_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         c_ff <= c_in;
      end
   end

   // Stage 3: numerator 3000*l - s*m*C, never negative for saturated inputs.
   assign term     = $signed({8'b0, sm_s2}) * 21'(c_ff);
   assign num_full = $signed({2'b0, lscaled_s2}) - term;
   assign num_in   = num_full[hsl2rgb_pkg::NUM_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         num_ff <= num_in;
      end
   end

   // Stage 4: scale by 255/300000 with a reciprocal multiply and a shift.
   assign scaled = hsl2rgb_pkg::PROD_W'(num_ff) * hsl2rgb_pkg::PROD_W'(hsl2rgb_pkg::RECIP_MULT);
   assign level_in = scaled[hsl2rgb_pkg::RECIP_SHIFT +: hsl2rgb_pkg::CHAN_W];

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

>>> rtl/core/hsl_to_rgb_converter_core.sv
// Channel     Dir  Handshake            Payload
// req_chan    in   valid / ready        hue[8:0], saturation[6:0], lightness[6:0]
// rsp_chan    out  valid / ready        red[7:0], green[7:0], blue[7:0]
//
// Four register stages: input normalize, shared products and channel clamp,
// numerator, and reciprocal scale into the output register.
// One item per cycle while results are taken; items pass the stages in order.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled result holds and bubbles close up behind it.
// Reset is synchronous and clears only the stage valid bits.
module hsl_to_rgb_converter_core (
   input  logic           clock,
   input  logic           reset,
   hsl2rgb_req_if.sink    req_chan,
   hsl2rgb_rsp_if.source  rsp_chan
);

   hsl2rgb_pkg::hsl2rgb_stage_en_type stage_en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [hsl2rgb_pkg::HUE_W-1:0]  hue_s1;
   logic [hsl2rgb_pkg::SM_W-1:0]   sm_s2;
   logic [hsl2rgb_pkg::NUM_W-1:0]  lscaled_s2;
   logic [hsl2rgb_pkg::CHAN_W-1:0] red_level, green_level, blue_level;

   // Stage enables ripple back from the output register.
   always_comb begin
      stage_en.s4 = !v4_ff || rsp_chan.ready;
      stage_en.s3 = !v3_ff || stage_en.s4;
      stage_en.s2 = !v2_ff || stage_en.s3;
      stage_en.s1 = !v1_ff || stage_en.s2;
   end

   assign req_chan.ready = stage_en.s1;

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (stage_en.s1) v1_ff <= req_chan.valid;
         if (stage_en.s2) v2_ff <= v1_ff;
         if (stage_en.s3) v3_ff <= v2_ff;
         if (stage_en.s4) v4_ff <= v3_ff;
      end
   end

   // Shared front end.
   hsl2rgb_front u_front (
      .clock      (clock),
      .stage_en   (stage_en),
      .hue        (req_chan.hue),
      .saturation (req_chan.saturation),
      .lightness  (req_chan.lightness),
      .hue_s1     (hue_s1),
      .sm_s2      (sm_s2),
      .lscaled_s2 (lscaled_s2)
   );

   // One lane per color channel.
   hsl2rgb_chan u_red (
      .clock      (clock),
      .stage_en   (stage_en),
      .offset     (hsl2rgb_pkg::RED_OFFSET),
      .hue_s1     (hue_s1),
      .sm_s2      (sm_s2),
      .lscaled_s2 (lscaled_s2),
      .level      (red_level)
   );

   hsl2rgb_chan u_green (
      .clock      (clock),
      .stage_en   (stage_en),
      .offset     (hsl2rgb_pkg::GREEN_OFFSET),
      .hue_s1     (hue_s1),
      .sm_s2      (sm_s2),
      .lscaled_s2 (lscaled_s2),
      .level      (green_level)
   );

   hsl2rgb_chan u_blue (
      .clock      (clock),
      .stage_en   (stage_en),
      .offset     (hsl2rgb_pkg::BLUE_OFFSET),
      .hue_s1     (hue_s1),
      .sm_s2      (sm_s2),
      .lscaled_s2 (lscaled_s2),
      .level      (blue_level)
   );

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.red   = red_level;
   assign rsp_chan.green = green_level;
   assign rsp_chan.blue  = blue_level;

   // Occupancy bookkeeping for the checks below.
   logic [2:0] occupancy;
   logic       taken, delivered;

   assign occupancy = 3'($countones({v1_ff, v2_ff, v3_ff, v4_ff}));
   assign taken     = req_chan.valid && req_chan.ready;
   assign delivered = rsp_chan.valid && rsp_chan.ready;

   // The input is held off only when every stage is full and the output stalls.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_chan.ready))
      else $error("input blocked while the pipeline has room");

   // Items in flight change only by what enters and what leaves.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> occupancy == 3'($past(occupancy) + 3'($past(taken))
                                         - 3'($past(delivered))))
      else $error("item lost or duplicated in the pipeline");

   // A waiting result keeps its color until it is taken.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(red_level) && $stable(green_level)
          && $stable(blue_level)))
      else $error("stalled result changed");

endmodule

>>> bench/hsl_to_rgb_converter_core_test.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_core_test;

   // Scale of the final division: channel = CHAN_FULL * num / NUM_FULL.
   localparam int CHAN_FULL = 255;
   localparam int NUM_FULL = 300000;
   localparam int RANDOM_ITEMS = 1030;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [hsl2rgb_pkg::HUE_W-1:0] hue;
      logic [hsl2rgb_pkg::PCT_W-1:0] saturation;
      logic [hsl2rgb_pkg::PCT_W-1:0] lightness;
   } hsl_color_type;

   typedef struct packed {
      logic [hsl2rgb_pkg::CHAN_W-1:0] red;
      logic [hsl2rgb_pkg::CHAN_W-1:0] green;
      logic [hsl2rgb_pkg::CHAN_W-1:0] blue;
   } rgb_color_type;

   logic clock;
   logic reset;

   hsl_color_type colors_to_send[$];
   rgb_color_type rgb_expected[$];
   int error_count = 0;
   int stall_cycles = 0;

   hsl2rgb_req_if req_if ();
   hsl2rgb_rsp_if rsp_if ();

   hsl_to_rgb_converter_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // One channel of the closed-form conversion, exact integer arithmetic.
   function automatic logic [hsl2rgb_pkg::CHAN_W-1:0] channel_level(
         int hue_deg, int sat, int light, logic [8:0] offset);
      int k;
      int c;
      int m;
      longint num;
      k = (int'(offset) + hue_deg) % hsl2rgb_pkg::HUE_FULL;
      c = k - hsl2rgb_pkg::K_RISE;
      if (hsl2rgb_pkg::K_FALL - k < c) c = hsl2rgb_pkg::K_FALL - k;
      if (c > hsl2rgb_pkg::C_LIMIT) c = hsl2rgb_pkg::C_LIMIT;
      if (c < -hsl2rgb_pkg::C_LIMIT) c = -hsl2rgb_pkg::C_LIMIT;
      m = (light < hsl2rgb_pkg::PCT_MAX - light) ? light : hsl2rgb_pkg::PCT_MAX - light;
      num = longint'(hsl2rgb_pkg::L_SCALE) * light - longint'(sat) * m * c;
      num = (num * CHAN_FULL) / NUM_FULL;
      return num[hsl2rgb_pkg::CHAN_W-1:0];
   endfunction

   // Normalizes the inputs (hue wraps, percentages saturate), then converts.
   function automatic rgb_color_type predict_rgb(hsl_color_type color);
      int hue_deg;
      int sat;
      int light;
      rgb_color_type rgb;
      hue_deg = int'(color.hue) % hsl2rgb_pkg::HUE_FULL;
      sat = (int'(color.saturation) > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                           : int'(color.saturation);
      light = (int'(color.lightness) > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                            : int'(color.lightness);
      rgb.red = channel_level(hue_deg, sat, light, hsl2rgb_pkg::RED_OFFSET);
      rgb.green = channel_level(hue_deg, sat, light, hsl2rgb_pkg::GREEN_OFFSET);
      rgb.blue = channel_level(hue_deg, sat, light, hsl2rgb_pkg::BLUE_OFFSET);
      return rgb;
   endfunction

   function automatic void add_color(int hue, int sat, int light);
      hsl_color_type color;
      color.hue = hue[hsl2rgb_pkg::HUE_W-1:0];
      color.saturation = sat[hsl2rgb_pkg::PCT_W-1:0];
      color.lightness = light[hsl2rgb_pkg::PCT_W-1:0];
      colors_to_send.push_back(color);
   endfunction

   // Mostly in-range percentages, with some above one hundred.
   function automatic int random_percent();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(hsl2rgb_pkg::PCT_MAX + 1, (1 << hsl2rgb_pkg::PCT_W) - 1);
      return $urandom_range(0, hsl2rgb_pkg::PCT_MAX);
   endfunction

   task automatic check_field(string name, logic [hsl2rgb_pkg::CHAN_W-1:0] expected_value,
                              logic [hsl2rgb_pkg::CHAN_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected_value, actual_value);
         error_count++;
      end
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Sender: bursts of random length, sometimes separated by random gaps.
   always @(posedge clock) begin
      static int burst_left = 0;
      static int gap_left = 0;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            rgb_expected.push_back(predict_rgb(colors_to_send.pop_front()));
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (colors_to_send.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.hue <= colors_to_send[0].hue;
               req_if.saturation <= colors_to_send[0].saturation;
               req_if.lightness <= colors_to_send[0].lightness;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a rotating stall pattern, and one long hold-off once HOLD_AFTER results are taken.
   always @(posedge clock) begin
      static logic [31:0] pattern_cycle = '0;
      static int taken = 0;
      static int hold_left = 0;
      static bit hold_done = 1'b0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) taken++;
         if (!hold_done && taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            pattern_cycle++;
            case (pattern_cycle[7:6])
               2'd0: rsp_if.ready <= 1'b1;
               2'd1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2'd2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Monitor: each result against the oldest expectation.
   always @(posedge clock) begin
      rgb_color_type expected_rgb;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rgb_expected.size() == 0) begin
            $error("unexpected result: red %0d, green %0d, blue %0d",
                   rsp_if.red, rsp_if.green, rsp_if.blue);
            error_count++;
         end else begin
            expected_rgb = rgb_expected.pop_front();
            check_field("red", expected_rgb.red, rsp_if.red);
            check_field("green", expected_rgb.green, rsp_if.green);
            check_field("blue", expected_rgb.blue, rsp_if.blue);
         end
      end
   end

   // Watchdog: cycles in which no item moves on either side.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      req_if.valid = 1'b0;
      req_if.hue = '0;
      req_if.saturation = '0;
      req_if.lightness = '0;
      rsp_if.ready = 1'b0;
      reset = 1'b1;

      // Primary and secondary hues at full saturation, then the wrap points.
      add_color(0, 100, 50);
      add_color(120, 100, 50);
      add_color(240, 100, 50);
      add_color(60, 100, 50);
      add_color(180, 100, 50);
      add_color(300, 100, 50);
      add_color(360, 100, 50);
      add_color(361, 100, 50);
      add_color(359, 100, 50);
      add_color(511, 127, 127);
      // Black, white, and the lightness extremes at full saturation.
      add_color(0, 0, 0);
      add_color(0, 0, 100);
      add_color(0, 100, 0);
      add_color(0, 100, 100);
      // Percentages above one hundred saturate.
      add_color(90, 101, 60);
      add_color(270, 127, 40);
      add_color(30, 50, 101);
      add_color(150, 75, 127);
      // Grey, near-black, and points on the rising and falling ramps.
      add_color(210, 0, 50);
      add_color(330, 1, 1);
      add_color(45, 100, 25);
      add_color(200, 100, 75);
      add_color(256, 64, 64);
      add_color(100, 99, 49);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_color($urandom_range(hsl2rgb_pkg::HUE_FULL, (1 << hsl2rgb_pkg::HUE_W) - 1),
                      random_percent(), random_percent());
         end else begin
            add_color($urandom_range(0, hsl2rgb_pkg::HUE_FULL - 1), random_percent(),
                      random_percent());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while ((colors_to_send.size() != 0 || rgb_expected.size() != 0)
             && stall_cycles < STALL_LIMIT)
         @(posedge clock);
      if (stall_cycles < STALL_LIMIT) repeat (8) @(posedge clock);

      if (stall_cycles >= STALL_LIMIT || error_count != 0 || rgb_expected.size() != 0) begin
         if (rgb_expected.size() != 0)
            $error("%0d expected results never arrived", rgb_expected.size());
         $display("Testbench completed WITH ERRORS");
      end else begin
         $display("Testbench completed without errors");
      end
      $finish;
   end

endmodule

>>> hsl_to_rgb_converter_core.f
rtl/core/hsl2rgb_pkg.sv
rtl/core/hsl2rgb_ifs.sv
rtl/core/hsl2rgb_front.sv
rtl/core/hsl2rgb_chan.sv
rtl/core/hsl_to_rgb_converter_core.sv
bench/hsl_to_rgb_converter_core_test.sv
